/* src/spq_pkg.sv */
// Shared types and constants for the sorted priority queue.
// Depends on nothing; every other file imports it.
package spq_pkg;

  localparam int PrioW     = 16;
  localparam int DataW     = 32;
  localparam int CntOutW   = 5;
  localparam int DepthDflt = 16;

  typedef enum logic {
    OpInsert = 1'b0,
    OpDelete = 1'b1
  } spq_op_t;

  typedef struct packed {
    spq_op_t                  operation;
    logic signed [PrioW-1:0]  priority_req;
    logic        [DataW-1:0]  payload;
  } spq_req_t;

  typedef struct packed {
    logic                     removed_valid;
    logic signed [PrioW-1:0]  removed_priority;
    logic        [DataW-1:0]  removed_payload;
    logic                     insert_dropped;
    logic                     head_valid;
    logic signed [PrioW-1:0]  head_priority;
    logic        [DataW-1:0]  head_payload;
    logic        [CntOutW-1:0] entry_count;
  } spq_rsp_t;

  // One stored entry.
  typedef struct packed {
    logic signed [PrioW-1:0] prio;
    logic        [DataW-1:0] data;
  } spq_slot_t;

  // Broadcast to every cell in the chain.
  typedef struct packed {
    logic      do_insert;
    logic      do_delete;
    spq_slot_t entry;
  } spq_ctrl_t;

endpackage

/* src/spq_cell.sv */
// One slot of the sorted chain: holds an entry, shifts toward the tail on
// insert and toward the head on delete. Depends on spq_pkg.
module spq_cell
  import spq_pkg::*;
(
  input  logic      clk,
  input  spq_ctrl_t ctrl,
  input  logic      valid,     // slot index is below the entry count
  input  logic      prev_ge,   // slot toward the head stays in place on insert
  input  spq_slot_t prev_slot,
  input  spq_slot_t next_slot,
  output spq_slot_t slot,
  output logic      ge
);

  spq_slot_t slot_next;

  // Stored entry stays ahead of the new one when its priority is not lower.
  assign ge = valid && ($signed(slot.prio) >= $signed(ctrl.entry.prio));

  always_comb begin
    slot_next = slot;
    if (ctrl.do_insert) begin
      if (ge) begin
        slot_next = slot;
      end else if (prev_ge) begin
        slot_next = ctrl.entry;
      end else begin
        slot_next = prev_slot;
      end
    end else if (ctrl.do_delete) begin
      slot_next = next_slot;
    end
  end

  always_ff @(posedge clk) begin
    slot <= slot_next;
  end

endmodule

/* src/sorted_priority_queue.sv */
// Top level of the stable sorted priority queue: chain of spq_cell slots,
// entry counter and response register. Depends on spq_pkg and spq_cell.
//
//   channel  direction  payload    meaning
//   req      in         spq_req_t  insert (priority, payload) or delete head
//   rsp      out        spq_rsp_t  removed entry, drop flag, head, count
//
// One request per cycle while the response side keeps up: every slot compares
// its priority with the new one in parallel and all shift together, so a request
// is answered on the next edge and the next request may enter at once.
// req_ready is high whenever the response register is empty or being taken.
// Reset clears the entry count and the response valid; slot contents are not
// cleared, slots at or above the count are never shown.
// A stalled response holds its register and blocks only further requests.
module sorted_priority_queue
  import spq_pkg::*;
#(
  parameter int DEPTH = DepthDflt
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  input  spq_req_t req,
  output logic     rsp_valid,
  input  logic     rsp_ready,
  output spq_rsp_t rsp
);

  localparam int CntW = $clog2(DEPTH + 1);

  logic [CntW-1:0] count;
  logic [CntW-1:0] count_next;
  logic            accept;
  logic            full;
  logic            empty;
  spq_ctrl_t       ctrl;
  spq_slot_t       slot  [DEPTH];
  logic            ge    [DEPTH];
  logic            cell_valid [DEPTH];
  spq_slot_t       head_next;
  spq_rsp_t        rsp_next;

  // Take a new request whenever the response register can be refilled.
  assign req_ready = !rsp_valid || rsp_ready;
  assign accept    = req_valid && req_ready;

  assign full  = (count == CntW'(DEPTH));
  assign empty = (count == '0);

  // Drop inserts into a full queue; ignore deletes on an empty one.
  assign ctrl.do_insert  = accept && (req.operation == OpInsert) && !full;
  assign ctrl.do_delete  = accept && (req.operation == OpDelete) && !empty;
  assign ctrl.entry.prio = req.priority_req;
  assign ctrl.entry.data = req.payload;

  always_comb begin
    count_next = count;
    if (ctrl.do_insert) begin
      count_next = count + 1'b1;
    end else if (ctrl.do_delete) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Chain of slots; slot 0 is the head.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    spq_slot_t prev_slot;
    spq_slot_t next_slot;
    logic      prev_ge;

    assign cell_valid[i] = (CntW'(i) < count);

    if (i == 0) begin : g_head
      assign prev_ge   = 1'b1;
      assign prev_slot = ctrl.entry;
    end else begin : g_body
      assign prev_ge   = ge[i-1];
      assign prev_slot = slot[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign next_slot = slot[i];
    end else begin : g_mid
      assign next_slot = slot[i+1];
    end

    spq_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .valid     (cell_valid[i]),
      .prev_ge   (prev_ge),
      .prev_slot (prev_slot),
      .next_slot (next_slot),
      .slot      (slot[i]),
      .ge        (ge[i])
    );
  end

  // Head as it stands after this request.
  always_comb begin
    head_next = slot[0];
    if (ctrl.do_insert && !ge[0]) begin
      head_next = ctrl.entry;
    end else if (ctrl.do_delete) begin
      head_next = slot[1];
    end
  end

  always_comb begin
    rsp_next                  = '0;
    rsp_next.removed_valid    = ctrl.do_delete;
    rsp_next.insert_dropped   = accept && (req.operation == OpInsert) && full;
    rsp_next.head_valid       = (count_next != '0);
    rsp_next.entry_count      = CntOutW'(count_next);
    if (ctrl.do_delete) begin
      rsp_next.removed_priority = slot[0].prio;
      rsp_next.removed_payload  = slot[0].data;
    end
    if (count_next != '0) begin
      rsp_next.head_priority = head_next.prio;
      rsp_next.head_payload  = head_next.data;
    end
  end

  // Response register: load on accept, drop valid once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp <= rsp_next;
    end
  end

endmodule

/* src/spq_checker.sv */
// Port-level assertions for the sorted priority queue, bound to the top.
// Depends on spq_pkg and sorted_priority_queue.
module spq_port_checks
  import spq_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     req_valid,
  input logic     req_ready,
  input spq_req_t req,
  input logic     rsp_valid,
  input logic     rsp_ready,
  input spq_rsp_t rsp
);

  // Hold a stalled response.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("stalled response changed");

  // Answer every request on the next edge.
  a_req_answered: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> rsp_valid)
    else $error("accepted request got no response");

  // An empty queue shows no head and a zero count.
  a_empty_head: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.head_valid |-> rsp.entry_count == '0 && rsp.head_priority == '0
      && rsp.head_payload == '0)
    else $error("empty queue shows a head");

  // A delete removes an entry exactly when the previous count was nonzero.
  a_delete_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_ready && req_valid && req_ready && req.operation == OpDelete
      |=> rsp.removed_valid == ($past(rsp.entry_count) != '0))
    else $error("delete result disagrees with previous count");

endmodule

bind sorted_priority_queue spq_port_checks u_spq_port_checks (.*);

/* bench/spq_checker.sv */
// Response checker for the sorted priority queue: shadows the sorted store,
// predicts one response per accepted request and compares it field by field.
// Depends on spq_pkg.
module spq_checker
  import spq_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  input  logic     req_ready,
  input  spq_req_t req,
  input  logic     rsp_valid,
  input  logic     rsp_ready,
  input  spq_rsp_t rsp,
  output int       mismatch_count,
  output int       awaited_count
);

  spq_slot_t sorted_entries[$];   // slot 0 is the head
  spq_rsp_t  awaited_rsp[$];
  int        errors = 0;

  assign mismatch_count = errors;

  // Apply one request to the shadow store and return the response it causes.
  function automatic spq_rsp_t serve_request(spq_req_t r);
    spq_rsp_t                o;
    spq_slot_t               e;
    logic signed [PrioW-1:0] new_prio;
    logic signed [PrioW-1:0] slot_prio;
    int                      pos;
    o = '0;
    if (r.operation == OpInsert) begin
      if (sorted_entries.size() >= DepthDflt) begin
        o.insert_dropped = 1'b1;
      end else begin
        new_prio = r.priority_req;
        pos = 0;
        // Skip every entry of greater or equal priority: ties stay in arrival order.
        while (pos < sorted_entries.size()) begin
          slot_prio = sorted_entries[pos].prio;
          if (slot_prio < new_prio) break;
          pos++;
        end
        e.prio = new_prio;
        e.data = r.payload;
        sorted_entries.insert(pos, e);
      end
    end else if (sorted_entries.size() > 0) begin
      e = sorted_entries.pop_front();
      o.removed_valid    = 1'b1;
      o.removed_priority = e.prio;
      o.removed_payload  = e.data;
    end
    if (sorted_entries.size() > 0) begin
      o.head_valid    = 1'b1;
      o.head_priority = sorted_entries[0].prio;
      o.head_payload  = sorted_entries[0].data;
    end
    o.entry_count = CntOutW'(sorted_entries.size());
    return o;
  endfunction

  task automatic compare_field(string field, logic [DataW-1:0] want, logic [DataW-1:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s expected %0h got %0h", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    spq_rsp_t want;
    if (rst) begin
      sorted_entries.delete();
      awaited_rsp.delete();
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (awaited_rsp.size() == 0) begin
          errors++;
          $display("%0t: response with no request pending: %h", $time, rsp);
        end else begin
          want = awaited_rsp.pop_front();
          compare_field("removed_valid", DataW'(want.removed_valid),
                        DataW'(rsp.removed_valid));
          compare_field("removed_priority", DataW'(want.removed_priority),
                        DataW'(rsp.removed_priority));
          compare_field("removed_payload", want.removed_payload, rsp.removed_payload);
          compare_field("insert_dropped", DataW'(want.insert_dropped),
                        DataW'(rsp.insert_dropped));
          compare_field("head_valid", DataW'(want.head_valid), DataW'(rsp.head_valid));
          compare_field("head_priority", DataW'(want.head_priority),
                        DataW'(rsp.head_priority));
          compare_field("head_payload", want.head_payload, rsp.head_payload);
          compare_field("entry_count", DataW'(want.entry_count), DataW'(rsp.entry_count));
        end
      end
      if (req_valid && req_ready) begin
        awaited_rsp.push_back(serve_request(req));
      end
    end
    awaited_count <= awaited_rsp.size();
  end

endmodule

/* bench/tb.sv */
// Top of the sorted priority queue bench: clock, reset, request stimulus and
// response-side stalls. Depends on spq_pkg, sorted_priority_queue, spq_checker.
module tb
  import spq_pkg::*;
();

  localparam int CycleLimit = 200000;
  localparam int PhaseItems = 417;

  logic     clk       = 1'b0;
  logic     rst       = 1'b1;
  logic     req_valid = 1'b0;
  spq_req_t req       = '0;
  logic     rsp_ready = 1'b0;
  logic     req_ready;
  logic     rsp_valid;
  spq_rsp_t rsp;

  int send_idle_pct = 36;
  int recv_idle_pct = 48;
  int mismatches;
  int awaited;
  int cycles = 0;

  sorted_priority_queue DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  spq_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .req_valid      (req_valid),
    .req_ready      (req_ready),
    .req            (req),
    .rsp_valid      (rsp_valid),
    .rsp_ready      (rsp_ready),
    .rsp            (rsp),
    .mismatch_count (mismatches),
    .awaited_count  (awaited)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Abort a hung run: reaching the cycle limit counts as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic spq_req_t make_req(spq_op_t op, logic [PrioW-1:0] prio,
                                        logic [DataW-1:0] data);
    spq_req_t r;
    r.operation    = op;
    r.priority_req = prio;
    r.payload      = data;
    return r;
  endfunction

  // Offer one request and return at the edge that accepts it. Sample ready at
  // the falling edge, where everything has settled, so acceptance is known
  // before the rising edge without racing the block's own updates.
  task automatic offer_request(spq_req_t r);
    logic rdy;
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    // Hold valid high and the request steady until it is taken.
    req_valid <= 1'b1;
    req       <= r;
    do begin
      @(negedge clk);
      rdy = req_ready;
      @(posedge clk);
    end while (!rdy);
  endtask

  // Response side: random stalls per the current idle rate, plus a long
  // periodic hold-off so the response register backs up and the
  // block drops req_ready while requests keep coming.
  initial begin
    int hold_left;
    int tick;
    hold_left = 0;
    tick      = 0;
    do @(posedge clk); while (rst);
    forever begin
      tick++;
      if (tick % 700 == 300) hold_left = 64;
      if (hold_left > 0) begin
        rsp_ready <= 1'b0;
        hold_left--;
      end else begin
        rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
      @(posedge clk);
    end
  end

  initial begin
    int               phase;
    int               n;
    int               burst;
    int               ins_pct;
    int               pick;
    spq_op_t          op;
    logic [PrioW-1:0] prio;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: delete on an empty queue with junk in the ignored fields.
    offer_request(make_req(OpDelete, 16'h7FFF, 32'hFFFF_FFFF));
    // Extremes of priority and payload, and a tie with the highest priority.
    offer_request(make_req(OpInsert, 16'h7FFF, 32'hFFFF_FFFF));
    offer_request(make_req(OpInsert, 16'h8000, 32'h0000_0000));
    offer_request(make_req(OpInsert, 16'h0000, 32'hA5A5_A5A5));
    offer_request(make_req(OpInsert, 16'h7FFF, 32'h0000_0001));
    // Drain: ties must leave in arrival order.
    offer_request(make_req(OpDelete, 16'h0000, 32'h0000_0000));
    offer_request(make_req(OpDelete, 16'h8000, 32'h5A5A_5A5A));
    offer_request(make_req(OpDelete, 16'h1234, 32'h0000_0000));
    offer_request(make_req(OpInsert, 16'h0000, 32'h0000_0002));
    offer_request(make_req(OpDelete, 16'h0000, 32'h0000_0000));
    offer_request(make_req(OpDelete, 16'h0000, 32'h0000_0000));
    // Fill to capacity with many ties, overflow once, then delete while full.
    for (n = 0; n < DepthDflt; n++) begin
      offer_request(make_req(OpInsert, PrioW'($urandom_range(3)) - PrioW'(1), $urandom));
    end
    offer_request(make_req(OpInsert, 16'h7FFF, 32'hDEAD_BEEF));
    offer_request(make_req(OpDelete, 16'h0000, 32'h0000_0000));

    // Random part in three idle settings: sender busy/receiver slow, the
    // reverse, then no idling at all. Bursts lean toward inserts or deletes
    // so the queue keeps swinging between full and empty.
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 36;
          recv_idle_pct = 48;
        end
        1: begin
          send_idle_pct = 48;
          recv_idle_pct = 36;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      n = 0;
      while (n < PhaseItems) begin
        case ($urandom_range(2))
          0:       ins_pct = 80;
          1:       ins_pct = 25;
          default: ins_pct = 55;
        endcase
        for (burst = $urandom_range(8, 40); burst > 0 && n < PhaseItems; burst--) begin
          op   = ($urandom_range(99) < ins_pct) ? OpInsert : OpDelete;
          pick = $urandom_range(9);
          // Mostly a narrow band for ties, some full range, some extremes.
          if (pick < 6)       prio = PrioW'($urandom_range(8)) - PrioW'(4);
          else if (pick < 8)  prio = PrioW'($urandom);
          else if (pick == 8) prio = 16'h7FFF;
          else                prio = 16'h8000;
          offer_request(make_req(op, prio, $urandom));
          n++;
        end
      end
    end
    req_valid <= 1'b0;

    // Drain: wait for every predicted response.
    do @(negedge clk); while (awaited != 0);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
